// ===== hw/rtl/ephf_pkg.sv =====
package ephf_pkg;

    // Count, pixel and command widths
    localparam int CNT_W = 8;
    localparam int CMD_W = 2;

    // Quotient width: 127 * 255 fits in 15 bits
    localparam int NUM_W = 15;

    localparam logic [CMD_W-1:0] CMD_ADD_EVENT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_PIXEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END_FRAME  = 2'd2;

    localparam logic [CNT_W-1:0] PIX_MIN = 8'd0;
    localparam logic [CNT_W-1:0] PIX_MID = 8'd128;
    localparam logic [CNT_W-1:0] PIX_MAX = 8'd255;
    localparam logic [CNT_W-1:0] SCALE   = 8'd127;

endpackage

// ===== hw/rtl/ephf_div.sv =====
module ephf_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ephf_pkg::NUM_W-1:0] num,
    input  logic [ephf_pkg::CNT_W-1:0] den,
    output logic                       done,
    output logic [ephf_pkg::NUM_W-1:0] quot
);
    import ephf_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND} div_state_t;

    div_state_t          state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    den_reg;
    logic                done_reg;
    logic [NUM_W-1:0]    quot_reg;

    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                fits;
    logic [CNT_W:0]      rem2;
    logic                round_up;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    // Round to nearest, ties to even
    assign rem2     = {rem_reg, 1'b0};
    assign round_up = (rem2 > {1'b0, den_reg}) || ((rem2 == {1'b0, den_reg}) && quo_reg[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            done_reg  <= 1'b0;
            quot_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        quo_reg   <= num;
                        rem_reg   <= '0;
                        den_reg   <= den;
                        step_reg  <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], fits};
                    if (step_reg == STEP_W'(NUM_W - 1))
                    begin
                        state_reg <= D_ROUND;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                D_ROUND:
                begin
                    quot_reg  <= quo_reg + NUM_W'(round_up);
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== hw/rtl/event_polarity_histogram_frame.sv =====
// Channel   | Direction | Handshake            | Word
// ----------+-----------+----------------------+------------------------------------------
// in        | input     | in_valid / in_stall  | command, x_coord, y_coord, polarity
// out       | output    | out_valid / out_stall| pixel_value
// cfg       | input     | cfg_valid / cfg_ready| cfg_display_mode
//
// An event updates the RAM in S_EVAL; a frame end completes in S_IDLE.
// Reads end in S_DONE; a histogram read runs the shared 15-step divider twice.
// Count RAM: one read port and one write port, one read-modify-write per word.
// After reset, sweep the count RAM to zero: all FRAME_WIDTH*FRAME_HEIGHT words
// (65536 at the default size) with in_stall high; cfg writes are taken meanwhile.
// A result waiting on out_stall holds the output register; new words are still
// accepted and only a finished read result waits for the register to free up.
module event_polarity_histogram_frame #(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ephf_pkg::CMD_W-1:0] command,
    input  logic [7:0]                 x_coord,
    input  logic [7:0]                 y_coord,
    input  logic                       polarity,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ephf_pkg::CNT_W-1:0] pixel_value,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_display_mode
);
    import ephf_pkg::*;

    localparam int PIX    = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = (PIX > 1) ? $clog2(PIX) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EVAL, S_DIV_ON, S_DIV_OFF, S_DONE
    } state_t;

    // 127 * count as shift and subtract
    function automatic logic [NUM_W-1:0] scale_cnt(input logic [CNT_W-1:0] c);
        return {c, 7'b0} - NUM_W'(c);
    endfunction

    // Count RAM: ON count in the upper byte, OFF count in the lower byte
    logic [2*CNT_W-1:0] cnt_mem [PIX];
    logic [2*CNT_W-1:0] rd_data_reg;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               mode_reg;
    logic [CNT_W-1:0]   max_on_reg, max_on_next;
    logic [CNT_W-1:0]   max_off_reg, max_off_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               is_read_reg, is_read_next;
    logic               pol_reg, pol_next;
    logic [CNT_W-1:0]   off_cnt_reg, off_cnt_next;
    logic [CNT_W-1:0]   top_reg, top_next;
    logic [CNT_W-1:0]   res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   pixel_reg, pixel_next;

    logic               in_accept;
    logic               in_frame;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [2*CNT_W-1:0] mem_wdata;
    logic [CNT_W-1:0]   on_cnt;
    logic [CNT_W-1:0]   off_cnt;
    logic [CNT_W-1:0]   on_inc;
    logic [CNT_W-1:0]   off_inc;
    logic [CNT_W-1:0]   den_max;

    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign in_frame = (32'(x_coord) < FRAME_WIDTH) && (32'(y_coord) < FRAME_HEIGHT);
    assign in_addr  = ADDR_W'(ADDR_W'(y_coord) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(x_coord));

    // Read straight from the port address while idle so the word is ready next cycle
    assign mem_raddr = (state_reg == S_IDLE) ? in_addr : addr_reg;

    assign on_cnt  = rd_data_reg[2*CNT_W-1:CNT_W];
    assign off_cnt = rd_data_reg[CNT_W-1:0];
    assign on_inc  = (on_cnt == PIX_MAX) ? PIX_MAX : on_cnt + 1'b1;
    assign off_inc = (off_cnt == PIX_MAX) ? PIX_MAX : off_cnt + 1'b1;
    assign den_max = (max_on_reg > max_off_reg) ? max_on_reg : max_off_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        max_on_next    = max_on_reg;
        max_off_next   = max_off_reg;
        addr_next      = addr_reg;
        is_read_next   = is_read_reg;
        pol_next       = pol_reg;
        off_cnt_next   = off_cnt_reg;
        top_next       = top_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        pixel_next     = pixel_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = '0;
        div_start      = 1'b0;
        div_num        = scale_cnt(on_cnt);

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the count RAM to zero, one word a cycle
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == ADDR_W'(PIX - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    addr_next = in_addr;
                    pol_next  = polarity;
                    unique case (command)
                        CMD_ADD_EVENT:
                        begin
                            is_read_next = 1'b0;
                            if (in_frame)
                            begin
                                state_next = S_EVAL;
                            end
                        end
                        CMD_READ_PIXEL:
                        begin
                            is_read_next = 1'b1;
                            if (in_frame)
                            begin
                                state_next = S_EVAL;
                            end
                            else
                            begin
                                // Out-of-frame read: mid grey, nothing cleared
                                res_next   = PIX_MID;
                                state_next = S_DONE;
                            end
                        end
                        CMD_END_FRAME:
                        begin
                            max_on_next  = '0;
                            max_off_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EVAL:
            begin
                mem_we = 1'b1;
                if (!is_read_reg)
                begin
                    // Saturating increment of one polarity, then advance its maximum
                    state_next = S_IDLE;
                    if (pol_reg)
                    begin
                        mem_wdata = {on_inc, off_cnt};
                        if (on_inc > max_on_reg)
                        begin
                            max_on_next = on_inc;
                        end
                    end
                    else
                    begin
                        mem_wdata = {on_cnt, off_inc};
                        if (off_inc > max_off_reg)
                        begin
                            max_off_next = off_inc;
                        end
                    end
                end
                else
                begin
                    // Read clears the pixel
                    mem_wdata = '0;
                    if (mode_reg)
                    begin
                        if (off_cnt != '0)
                        begin
                            res_next = PIX_MIN;
                        end
                        else if (on_cnt != '0)
                        begin
                            res_next = PIX_MAX;
                        end
                        else
                        begin
                            res_next = PIX_MID;
                        end
                        state_next = S_DONE;
                    end
                    else if (den_max == '0)
                    begin
                        res_next   = PIX_MID;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        off_cnt_next = off_cnt;
                        div_start    = 1'b1;
                        div_num      = scale_cnt(on_cnt);
                        state_next   = S_DIV_ON;
                    end
                end
            end
            S_DIV_ON:
            begin
                if (div_done)
                begin
                    // 128 + ON term, held at 255 when stale counts overshoot
                    top_next   = (div_quot >= NUM_W'(SCALE)) ? PIX_MAX
                                 : PIX_MID + CNT_W'(div_quot);
                    div_start  = 1'b1;
                    div_num    = scale_cnt(off_cnt_reg);
                    state_next = S_DIV_OFF;
                end
            end
            S_DIV_OFF:
            begin
                if (div_done)
                begin
                    res_next   = (NUM_W'(top_reg) > div_quot) ? top_reg - CNT_W'(div_quot)
                                 : PIX_MIN;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    pixel_next     = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            mode_reg      <= 1'b0;
            max_on_reg    <= '0;
            max_off_reg   <= '0;
            is_read_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pixel_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            max_on_reg    <= max_on_next;
            max_off_reg   <= max_off_next;
            is_read_reg   <= is_read_next;
            out_valid_reg <= out_valid_next;
            pixel_reg     <= pixel_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_display_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        pol_reg     <= pol_next;
        off_cnt_reg <= off_cnt_next;
        top_reg     <= top_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cnt_mem[mem_raddr];
    end

    ephf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_max),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_reg;

    // Divider results only arrive while a histogram read waits on them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_ON || state_reg == S_DIV_OFF))
        else $error("divider result outside a histogram read");

    // RAM writes come only from the clearing sweep or a read-modify-write
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_EVAL))
        else $error("count RAM written outside sweep or update");

    // Frame end leaves both maxima at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == CMD_END_FRAME) |=> (max_on_reg == '0 && max_off_reg == '0))
        else $error("maxima not cleared at frame end");

    // An in-frame event or read goes to the update state next
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_frame && (command == CMD_ADD_EVENT || command == CMD_READ_PIXEL))
        |=> (state_reg == S_EVAL))
        else $error("in-frame word skipped the RAM update");

    // A result is loaded only when the output register is free or being emptied
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result left while output register full");

endmodule
